// ----- hw/rtl/bcgd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bcgd_pkg;

	// counter and register widths
	localparam int COUNT_WIDTH = 16;
	localparam int CFG_WIDTH   = 16;
	localparam int CMP_W       = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

	// output queue
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = QPTR_W + 1;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK = 2'd2;

	// reset values
	localparam logic [CFG_WIDTH-1:0] RST_LONG_PRESS   = 16'd240;
	localparam logic [CFG_WIDTH-1:0] RST_MIN_PRESS    = 16'd6;
	localparam logic [CFG_WIDTH-1:0] RST_DOUBLE_CLICK = 16'd60;

	// request op codes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_EDGE = 1'b1;

	// gesture codes
	localparam logic [1:0] GEST_SINGLE = 2'd1;
	localparam logic [1:0] GEST_DOUBLE = 2'd2;
	localparam logic [1:0] GEST_LONG   = 2'd3;

	typedef struct packed {
		logic op;
		logic level;
	} in_req_t;

	typedef struct packed {
		logic [1:0] gesture;
		logic       last;
	} out_req_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] long_press_ticks;
		logic [CFG_WIDTH-1:0] min_press_ticks;
		logic [CFG_WIDTH-1:0] double_click_ticks;
	} cfg_t;

	// up to two events from one request, packed from slot 0
	typedef struct packed {
		logic       v0;
		logic [1:0] g0;
		logic       v1;
		logic [1:0] g1;
	} evt_t;

	function automatic logic [CMP_W-1:0] widen_cnt(input logic [COUNT_WIDTH-1:0] x);
		return CMP_W'(x);
	endfunction

	function automatic logic [CMP_W-1:0] widen_cfg(input logic [CFG_WIDTH-1:0] x);
		return CMP_W'(x);
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/button_click_gesture_detector.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Push-button gesture detector. Each input request is a timer tick (op 0) or
// a button edge (op 1) with the new level; results are single click (1),
// double click (2) or long press (3), with last set on the final result a
// request causes (a tick may give a long press followed by a single click).
// One request is taken every cycle while the queue has room: it sits in an
// input register while the counters and flags update, then its results go into
// a four-entry output queue. The input stalls only when the queue lacks room
// for two results, i.e. when the consumer holds off. Thresholds are whole tick
// counts in three 16-bit registers (index 0 long press, 1 minimum press, 2
// double-click window); write them only while the block is idle.
module button_click_gesture_detector (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire bcgd_pkg::in_req_t               in_req,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output bcgd_pkg::out_req_t                   out_req,
	input  wire logic                            cfg_we,
	input  wire logic [bcgd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bcgd_pkg::CFG_WIDTH-1:0]  cfg_wdata
);
	import bcgd_pkg::*;

	cfg_t cfg;
	evt_t evt;
	logic push;
	logic q_space;

	// threshold registers
	bcgd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// input register, counters and gesture logic
	bcgd_classify u_cls (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_req   (in_req),
		.cfg      (cfg),
		.q_space  (q_space),
		.push     (push),
		.evt      (evt)
	);

	// result queue decouples output stalls from the input
	bcgd_out_fifo u_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.evt       (evt),
		.q_space   (q_space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_req   (out_req)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/bcgd_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bcgd_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bcgd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bcgd_pkg::CFG_WIDTH-1:0]  cfg_wdata,
	output bcgd_pkg::cfg_t                       cfg
);
	import bcgd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ticks   <= RST_LONG_PRESS;
			cfg_q.min_press_ticks    <= RST_MIN_PRESS;
			cfg_q.double_click_ticks <= RST_DOUBLE_CLICK;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LONG_PRESS:   cfg_q.long_press_ticks   <= cfg_wdata;
				REG_MIN_PRESS:    cfg_q.min_press_ticks    <= cfg_wdata;
				REG_DOUBLE_CLICK: cfg_q.double_click_ticks <= cfg_wdata;
				default: ; // unmapped index: write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bcgd_classify.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bcgd_classify (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire bcgd_pkg::in_req_t  in_req,
	input  wire bcgd_pkg::cfg_t     cfg,
	input  wire logic               q_space,
	output logic                    push,
	output bcgd_pkg::evt_t          evt
);
	import bcgd_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	in_req_t                req_s1;
	logic                   valid_s1;
	logic [COUNT_WIDTH-1:0] hold_q, rel_q;
	logic                   up_q, lf_q, sp_q, dp_q;

	logic [COUNT_WIDTH-1:0] hold_d, rel_d;
	logic                   up_d, lf_d, sp_d, dp_d;
	logic                   long_ev, click, pend_ev;
	logic [1:0]             pend_g;
	logic                   adv;

	assign adv      = valid_s1 && q_space;
	assign in_ready = !valid_s1 || adv;
	assign push     = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_req;
		end
	end

	always_comb begin
		hold_d  = hold_q;
		rel_d   = rel_q;
		up_d    = up_q;
		lf_d    = lf_q;
		sp_d    = sp_q;
		dp_d    = dp_q;
		long_ev = 1'b0;
		click   = 1'b0;
		pend_ev = 1'b0;
		pend_g  = GEST_SINGLE;
		if (req_s1.op == OP_TICK) begin
			hold_d  = (hold_q == COUNT_MAX) ? hold_q : hold_q + 1'b1;
			rel_d   = (rel_q == COUNT_MAX) ? rel_q : rel_q + 1'b1;
			long_ev = !up_q && !lf_q &&
				(widen_cnt(hold_d) >= widen_cfg(cfg.long_press_ticks));
			if (long_ev) begin
				lf_d = 1'b1;
			end
		end else if (req_s1.level) begin
			if (up_q) begin
				hold_d = '0;
				lf_d   = 1'b0;
			end
			up_d = 1'b0;
		end else begin
			click = !up_q && !lf_q &&
				(widen_cnt(hold_q) >= widen_cfg(cfg.min_press_ticks));
			if (click) begin
				if (!sp_q && !dp_q) begin
					sp_d = 1'b1;
				end else if (sp_q && !dp_q) begin
					sp_d = 1'b0;
					dp_d = 1'b1;
				end
			end
			up_d  = 1'b1;
			rel_d = '0;
		end
		// pending check after every request
		if (dp_d) begin
			dp_d    = 1'b0;
			pend_ev = 1'b1;
			pend_g  = GEST_DOUBLE;
		end else if (sp_d &&
			(widen_cnt(rel_d) > widen_cfg(cfg.double_click_ticks))) begin
			sp_d    = 1'b0;
			pend_ev = 1'b1;
			pend_g  = GEST_SINGLE;
		end
	end

	// long press first, then the click
	always_comb begin
		evt.v0 = long_ev || pend_ev;
		evt.g0 = long_ev ? GEST_LONG : pend_g;
		evt.v1 = long_ev && pend_ev;
		evt.g1 = pend_g;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
			rel_q  <= '0;
			up_q   <= 1'b1;
			lf_q   <= 1'b0;
			sp_q   <= 1'b0;
			dp_q   <= 1'b0;
		end else if (adv) begin
			hold_q <= hold_d;
			rel_q  <= rel_d;
			up_q   <= up_d;
			lf_q   <= lf_d;
			sp_q   <= sp_d;
			dp_q   <= dp_d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/bcgd_out_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bcgd_out_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire bcgd_pkg::evt_t evt,
	output logic               q_space,
	output logic               out_valid,
	input  wire logic          out_ready,
	output bcgd_pkg::out_req_t out_req
);
	import bcgd_pkg::*;

	out_req_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wp_q, rp_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic [QCNT_W-1:0]   npush;
	logic                pop;
	out_req_t            e0, e1;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_req   = mem_q[rp_q];
	// two free slots needed for the worst-case request
	assign q_space   = (cnt_q <= QCNT_W'(QDEPTH - 2));

	always_comb begin
		npush = '0;
		if (push && evt.v0) begin
			npush = evt.v1 ? QCNT_W'(2) : QCNT_W'(1);
		end
		e0.gesture = evt.g0;
		e0.last    = !evt.v1;
		e1.gesture = evt.g1;
		e1.last    = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (push && evt.v0) begin
			mem_q[wp_q] <= e0;
			if (evt.v1) begin
				mem_q[wp_q + 1'b1] <= e1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QPTR_W'(npush);
			rp_q  <= rp_q + QPTR_W'(pop);
			cnt_q <= cnt_q + npush - QCNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/bcgd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bcgd_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_ready,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire bcgd_pkg::out_req_t out_req
);
	import bcgd_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_req))
		else $error("result changed while stalled");

	// gesture code zero is never produced
	a_gest_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_req.gesture != 2'd0)
		else $error("invalid gesture code");

	// only a long press can be followed by another result of the same request
	a_not_last_long: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_req.last |-> out_req.gesture == GEST_LONG)
		else $error("non-final result is not a long press");

	// input back-pressure only arises from queued results
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with nothing to deliver");

endmodule

bind button_click_gesture_detector bcgd_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_req   (out_req)
);

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the push-button gesture detector.
//
// Requests (ticks and button edges) go in through a valid/ready sender task.
// Every accepted request also runs through a local gesture predictor that
// keeps its own hold and release counters, button flags and thresholds.
// The predictor pushes the gestures that the request should cause onto a
// queue. A separate receiver process pops that queue for every accepted
// result and compares gesture and last field by field.
//
// Thresholds are rewritten only once the block has drained. The tests run in
// turn:
//   - default thresholds straight out of reset, with random gestures
//   - short directed sequences for the corner cases
//   - random phases under several threshold settings, extremes among them
//   - a long receiver hold-off, so the output queue fills and the input
//     stalls, then a pause until every result is back
module testbench;
	import bcgd_pkg::*;

	localparam int  CLK_HALF     = 6;
	localparam int  RESET_CYCLES = 6;
	// worst case is a sender idle gap plus two receiver stalls per request over a
	// few thousand requests, plus the long hold-offs; a wide margin on top
	localparam int  CYCLE_LIMIT  = 2_000_000;
	// request register plus output queue; enough for a request with no result
	// to clear the block before a threshold write
	localparam int  DRAIN_CYCLES = 8;
	// longest run of ticks a random burst asks for
	localparam int  BURST_CAP    = 300;
	localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = {COUNT_WIDTH{1'b1}};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_req_t               in_req    = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_req_t              out_req;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_WIDTH-1:0]  cfg_wdata = '0;

	// predictor state, mirrors the block after reset
	logic [CFG_WIDTH-1:0]   long_thr = RST_LONG_PRESS;
	logic [CFG_WIDTH-1:0]   min_thr  = RST_MIN_PRESS;
	logic [CFG_WIDTH-1:0]   dc_thr   = RST_DOUBLE_CLICK;
	logic [COUNT_WIDTH-1:0] hold_cnt = '0;
	logic [COUNT_WIDTH-1:0] rel_cnt  = '0;
	logic                   btn_up      = 1'b1;
	logic                   long_done   = 1'b0;
	logic                   single_wait = 1'b0;
	logic                   double_wait = 1'b0;

	out_req_t expected_gestures[$];

	int unsigned cycles     = 0;
	int          errors     = 0;
	int          phase_reqs = 0;
	// idle limits for each side; 0 gives back-to-back traffic
	int          tx_max_gap = 12;
	int          rx_max_gap = 12;
	// one-off long stall for the receiver, picked up after its next result
	int          rx_holdoff = 0;

	button_click_gesture_detector i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_req   (out_req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #CLK_HALF clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("button_click_gesture_detector test failed");
			$finish;
		end
	end

	// Gesture predictor: updates the local state for one request and queues
	// the gestures it causes, a long press ahead of a click on the same tick.
	function automatic void predict_gestures(in_req_t r);
		logic [1:0] ev [0:1];
		int         n;
		out_req_t   res;
		n = 0;
		if (r.op == OP_TICK) begin
			if (hold_cnt != COUNT_TOP) hold_cnt++;
			if (rel_cnt != COUNT_TOP) rel_cnt++;
			if (!btn_up && !long_done && hold_cnt >= long_thr) begin
				long_done = 1'b1;
				ev[n] = GEST_LONG;
				n++;
			end
		end else if (r.level) begin
			// press while already down keeps the running hold count
			if (btn_up) begin
				hold_cnt = '0;
				long_done = 1'b0;
			end
			btn_up = 1'b0;
		end else begin
			if (!btn_up && !long_done && hold_cnt >= min_thr) begin
				if (!single_wait && !double_wait) begin
					single_wait = 1'b1;
				end else if (single_wait && !double_wait) begin
					single_wait = 1'b0;
					double_wait = 1'b1;
				end
			end
			// release while up still restarts the window
			btn_up = 1'b1;
			rel_cnt = '0;
		end
		if (double_wait) begin
			double_wait = 1'b0;
			ev[n] = GEST_DOUBLE;
			n++;
		end else if (single_wait && rel_cnt > dc_thr) begin
			single_wait = 1'b0;
			ev[n] = GEST_SINGLE;
			n++;
		end
		for (int k = 0; k < n; k++) begin
			res.gesture = ev[k];
			res.last = (k == n - 1);
			expected_gestures.push_back(res);
		end
	endfunction

	// Offer one request after a random gap and hold it until accepted.
	// Valid is left high on return so back-to-back requests never drop it.
	task automatic send_request(logic op, logic level);
		int gap;
		gap = (tx_max_gap > 0) ? $urandom_range(0, tx_max_gap) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_req.op <= op;
		in_req.level <= level;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_gestures(in_req);
		phase_reqs++;
	endtask

	// level on a tick is don't-care, so it is randomised
	task automatic send_ticks(int n);
		for (int i = 0; i < n; i++) send_request(OP_TICK, 1'($urandom));
	endtask

	task automatic send_click(int held);
		send_request(OP_EDGE, 1'b1);
		send_ticks(held);
		send_request(OP_EDGE, 1'b0);
	endtask

	// Drop valid, let every expected gesture come back, then let a trailing
	// request that causes nothing pass through before touching thresholds.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_gestures.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes all three thresholds on consecutive edges; block must be idle.
	task automatic apply_thresholds(logic [CFG_WIDTH-1:0] lp, logic [CFG_WIDTH-1:0] mp,
			logic [CFG_WIDTH-1:0] dc);
		cfg_we <= 1'b1;
		cfg_index <= REG_LONG_PRESS;
		cfg_wdata <= lp;
		@(posedge clk);
		cfg_index <= REG_MIN_PRESS;
		cfg_wdata <= mp;
		@(posedge clk);
		cfg_index <= REG_DOUBLE_CLICK;
		cfg_wdata <= dc;
		@(posedge clk);
		cfg_we <= 1'b0;
		long_thr = lp;
		min_thr = mp;
		dc_thr = dc;
	endtask

	function automatic int capped(int x);
		return (x > BURST_CAP) ? BURST_CAP : x;
	endfunction

	// One random burst, sized around the current thresholds. Mostly real
	// gestures with random timing either side of each threshold; the rest
	// is noise and broken edge sequences.
	task automatic send_gesture_burst();
		int kind;
		int lo;
		kind = $urandom_range(0, 9);
		// occasional stretch with no idling on either side
		if ($urandom_range(0, 7) == 0) begin
			tx_max_gap = 0;
			rx_max_gap = 0;
		end else begin
			tx_max_gap = 12;
			rx_max_gap = 12;
		end
		lo = (min_thr > 2) ? int'(min_thr) - 2 : 0;
		case (kind)
			0, 1, 2: begin
				send_click(capped($urandom_range(lo, int'(min_thr) + 2)));
				send_ticks(capped($urandom_range(0, int'(dc_thr) + 3)));
			end
			3, 4: begin
				send_click(capped($urandom_range(lo, int'(min_thr) + 2)));
				send_ticks(capped($urandom_range(0, int'(dc_thr) + 1)));
				send_click(capped($urandom_range(lo, int'(min_thr) + 2)));
				send_ticks(capped($urandom_range(0, int'(dc_thr) + 3)));
			end
			5: begin
				send_click(capped(int'(long_thr) + $urandom_range(0, 3) - 1));
			end
			6, 7: begin
				repeat ($urandom_range(1, 6)) send_request(1'($urandom), 1'($urandom));
			end
			8: begin
				// repeated edges of the same level
				repeat ($urandom_range(1, 3)) send_request(OP_EDGE, 1'b1);
				send_ticks($urandom_range(0, 4));
				repeat ($urandom_range(1, 3)) send_request(OP_EDGE, 1'b0);
			end
			default: begin
				send_ticks(capped($urandom_range(0, int'(dc_thr) + 5)));
			end
		endcase
	endtask

	task automatic run_random_phase(int n_reqs);
		phase_reqs = 0;
		while (phase_reqs < n_reqs) send_gesture_burst();
		tx_max_gap = 12;
		rx_max_gap = 12;
		wait_idle();
	endtask

	// Reset values of the thresholds are only exercised here: no write yet.
	task automatic test_default_thresholds();
		run_random_phase(400);
	endtask

	task automatic test_directed_gestures();
		apply_thresholds(16'd3, 16'd1, 16'd2);
		send_request(OP_TICK, 1'b0);
		send_request(OP_TICK, 1'b1);
		// too short to count, then a release while already up
		send_click(0);
		send_request(OP_EDGE, 1'b0);
		// long press and a single click landing on the same tick, the single
		// reported while the button is held again
		send_click(1);
		send_request(OP_EDGE, 1'b1);
		send_ticks(3);
		// release after a long press counts no click
		send_request(OP_EDGE, 1'b0);
		// double click
		send_click(1);
		send_click(1);
		// press while down keeps the hold count
		send_request(OP_EDGE, 1'b1);
		send_ticks(1);
		send_request(OP_EDGE, 1'b1);
		send_ticks(2);
		send_request(OP_EDGE, 1'b0);
		wait_idle();
		// zero thresholds: long press on the first held tick, any hold counts
		apply_thresholds(16'd0, 16'd0, 16'd0);
		send_request(OP_EDGE, 1'b1);
		send_ticks(1);
		send_request(OP_EDGE, 1'b0);
		send_click(0);
		send_ticks(1);
		wait_idle();
	endtask

	task automatic test_random_gestures();
		apply_thresholds(16'($urandom_range(1, 40)), 16'($urandom_range(0, 8)),
			16'($urandom_range(0, 30)));
		run_random_phase(500);
		apply_thresholds(16'd1, 16'd0, 16'd0);
		run_random_phase(400);
		apply_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_random_phase(150);
		apply_thresholds(16'($urandom_range(1, 40)), 16'($urandom_range(0, 8)),
			16'($urandom_range(0, 30)));
		run_random_phase(400);
		apply_thresholds(16'hFFFF, 16'd0, 16'($urandom_range(0, 20)));
		run_random_phase(300);
	endtask

	// About one result every five requests with no sender gaps while the
	// receiver sits out a long stall: the output queue fills and in_ready drops.
	task automatic test_output_backpressure();
		apply_thresholds(16'd2, 16'd0, 16'd0);
		tx_max_gap = 0;
		for (int round = 0; round < 2; round++) begin
			rx_holdoff = 300;
			repeat (40) begin
				send_click(0);
				send_request(OP_EDGE, 1'b1);
				send_ticks(2);
			end
			// sender pauses until every result is back
			wait_idle();
			send_request(OP_EDGE, 1'b0);
		end
		tx_max_gap = 12;
		wait_idle();
	endtask

	// Receiver: random stall ahead of each result, then compare with the
	// oldest expected gesture.
	initial begin
		int       stall;
		out_req_t want;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_holdoff > 0) begin
				stall = rx_holdoff;
				rx_holdoff = 0;
			end else begin
				stall = (rx_max_gap > 0) ? $urandom_range(0, rx_max_gap) : 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (expected_gestures.size() == 0) begin
				$error("unexpected result: gesture %0d last %0d", out_req.gesture, out_req.last);
				errors++;
			end else begin
				want = expected_gestures.pop_front();
				if (out_req.gesture !== want.gesture) begin
					$error("gesture: expected %0d, got %0d", want.gesture, out_req.gesture);
					errors++;
				end
				if (out_req.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, out_req.last);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_thresholds();
		test_directed_gestures();
		test_random_gestures();
		test_output_backpressure();
		wait_idle();
		if (errors == 0) begin
			$display("button_click_gesture_detector test passed");
		end else begin
			$display("button_click_gesture_detector test failed");
		end
		$finish;
	end

endmodule
